// File: design/fsqc_pkg.sv
// Package for the fair share quota charger.
// Holds codes, fixed field widths and the controller/datapath interface structs.
// No dependencies.
package fsqc_pkg;

   localparam int SLOT_IN_W   = 4;
   localparam int SLOT_CODES  = 1 << SLOT_IN_W;
   localparam int BYTES_W     = 32;
   localparam int FDS_W       = 16;
   localparam int LIVE_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int ACTIVE_W    = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

   localparam logic FUNC_CHARGE  = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUOTA      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_CHARGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_COUNT_FULL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FD_LIMIT   = 1'd1;

   localparam logic [BYTES_W-1:0] BYTE_LIMIT_RESET = 32'd16777216;
   localparam logic [FDS_W-1:0]   FD_LIMIT_RESET   = 16'd64;

   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [FDS_W-1:0]   fds;
      logic [LIVE_W-1:0]  live;
   } usage_entry_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic eval;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

// File: design/fsqc_ctrl.sv
// Controller state machine of the fair share quota charger.
// Sequences clearing, memory read, evaluation and commit; owns the response valid.
// Depends on fsqc_pkg.
module fsqc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fsqc_pkg::ctrl_cmd_type cmd,
   input  fsqc_pkg::dp_status_type status
);
   import fsqc_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL, ST_COMMIT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      accept;
   logic      commit;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_COMMIT) && rsp_free);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_COMMIT) && rsp_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.accept = accept;
      cmd.eval   = (state_ff == ST_EVAL);
      cmd.commit = commit;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = accept ? ST_EVAL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/fsqc_datapath.sv
// Datapath of the fair share quota charger: config registers, owner and usage
// memories with write bypass, share multipliers, admission compare and response.
// Depends on fsqc_pkg.
module fsqc_datapath #(
   parameter int OWNER_SLOTS = 16,
   parameter int ACTOR_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fsqc_pkg::ctrl_cmd_type              cmd,
   output fsqc_pkg::dp_status_type             status,
   input  logic                               csr_wr_en,
   input  logic [fsqc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fsqc_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                               req_func,
   input  logic [fsqc_pkg::SLOT_IN_W-1:0]     req_owner_slot,
   input  logic [fsqc_pkg::SLOT_IN_W-1:0]     req_actor_slot,
   input  logic [fsqc_pkg::BYTES_W-1:0]       req_amount_bytes,
   input  logic [fsqc_pkg::FDS_W-1:0]         req_amount_fds,
   output logic [fsqc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fsqc_pkg::BYTES_W-1:0]       rsp_bytes_left,
   output logic [fsqc_pkg::FDS_W-1:0]         rsp_fds_left,
   output logic [fsqc_pkg::ACTIVE_W-1:0]      rsp_actors_active
);
   import fsqc_pkg::*;

   localparam int OW     = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
   localparam int AW     = (ACTOR_SLOTS > 1) ? $clog2(ACTOR_SLOTS) : 1;
   localparam int UDEPTH = OWNER_SLOTS * ACTOR_SLOTS;
   localparam int UAW    = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
   localparam int CW     = $clog2(ACTOR_SLOTS + 1);
   localparam int PBW    = BYTES_W + 1 + CW;
   localparam int PFW    = FDS_W + 1 + CW;

   // configuration
   logic [BYTES_W-1:0] byte_limit_ff;
   logic [FDS_W-1:0]   fd_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff <= BYTE_LIMIT_RESET;
         fd_limit_ff   <= FD_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BYTE_LIMIT: byte_limit_ff <= csr_wr_data;
            CSR_FD_LIMIT:   fd_limit_ff   <= csr_wr_data[FDS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // slot folding tables
   logic [OW-1:0] owner_map [SLOT_CODES];
   logic [AW-1:0] actor_map [SLOT_CODES];

   for (genvar i = 0; i < SLOT_CODES; i++) begin : g_map
      assign owner_map[i] = OW'(i % OWNER_SLOTS);
      assign actor_map[i] = AW'(i % ACTOR_SLOTS);
   end

   logic [OW-1:0]  owner_in;
   logic [UAW-1:0] usage_in;

   assign owner_in = owner_map[req_owner_slot];
   assign usage_in = UAW'(32'(owner_in) * ACTOR_SLOTS + 32'(actor_map[req_actor_slot]));

   // request registers
   logic                func_ff;
   logic [OW-1:0]       owner_ff;
   logic [UAW-1:0]      usage_ff;
   logic [BYTES_W-1:0]  nb_ff;
   logic [FDS_W-1:0]    nf_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         owner_ff <= owner_in;
         usage_ff <= usage_in;
         nb_ff    <= req_amount_bytes;
         nf_ff    <= req_amount_fds;
      end
   end

   // clearing sweep of the usage memory
   logic [UAW-1:0] clr_addr_ff;

   assign status.clear_last = (clr_addr_ff == UAW'(UDEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear && !status.clear_last) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // memories
   usage_entry_type    usage_mem [UDEPTH];
   logic [BYTES_W-1:0] own_bytes_mem [OWNER_SLOTS];
   logic [FDS_W-1:0]   own_fds_mem [OWNER_SLOTS];
   logic [CW-1:0]      own_act_mem [OWNER_SLOTS];
   logic               owner_valid_ff [OWNER_SLOTS];

   usage_entry_type    usage_rd_ff;
   logic [BYTES_W-1:0] own_bytes_rd_ff;
   logic [FDS_W-1:0]   own_fds_rd_ff;
   logic [CW-1:0]      own_act_rd_ff;

   usage_entry_type    use_new;
   logic [BYTES_W-1:0] bl_new;
   logic [FDS_W-1:0]   fl_new;
   logic [CW-1:0]      act_new;
   logic [STATUS_W-1:0] status_new;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         usage_mem[clr_addr_ff] <= '0;
      end else if (cmd.commit) begin
         usage_mem[usage_ff] <= use_new;
      end
      if (cmd.accept) begin
         usage_rd_ff <= usage_mem[usage_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         own_bytes_mem[owner_ff] <= bl_new;
         own_fds_mem[owner_ff]   <= fl_new;
         own_act_mem[owner_ff]   <= act_new;
      end
      if (cmd.accept) begin
         own_bytes_rd_ff <= own_bytes_mem[owner_in];
         own_fds_rd_ff   <= own_fds_mem[owner_in];
         own_act_rd_ff   <= own_act_mem[owner_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OWNER_SLOTS; i++) begin
            owner_valid_ff[i] <= 1'b0;
         end
      end else if (cmd.commit) begin
         owner_valid_ff[owner_ff] <= 1'b1;
      end
   end

   // bypass of the entry written in the same cycle as the next read
   logic               hit_owner_ff;
   logic               hit_usage_ff;
   usage_entry_type    byp_use_ff;
   logic [BYTES_W-1:0] byp_bl_ff;
   logic [FDS_W-1:0]   byp_fl_ff;
   logic [CW-1:0]      byp_act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_owner_ff <= 1'b0;
         hit_usage_ff <= 1'b0;
      end else if (cmd.accept) begin
         hit_owner_ff <= cmd.commit && (owner_in == owner_ff);
         hit_usage_ff <= cmd.commit && (usage_in == usage_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         byp_use_ff <= use_new;
         byp_bl_ff  <= bl_new;
         byp_fl_ff  <= fl_new;
         byp_act_ff <= act_new;
      end
   end

   // evaluation stage
   usage_entry_type    use_cur;
   logic [BYTES_W-1:0] bl_cur;
   logic [FDS_W-1:0]   fl_cur;
   logic [CW-1:0]      act_cur;
   logic [CW-1:0]      users;
   logic [BYTES_W:0]   share_b;
   logic [FDS_W:0]     share_f;

   always_comb begin
      use_cur = hit_usage_ff ? byp_use_ff : usage_rd_ff;
      if (!owner_valid_ff[owner_ff]) begin
         bl_cur  = byte_limit_ff;
         fl_cur  = fd_limit_ff;
         act_cur = '0;
      end else if (hit_owner_ff) begin
         bl_cur  = byp_bl_ff;
         fl_cur  = byp_fl_ff;
         act_cur = byp_act_ff;
      end else begin
         bl_cur  = own_bytes_rd_ff;
         fl_cur  = own_fds_rd_ff;
         act_cur = own_act_rd_ff;
      end
      users   = act_cur + CW'(use_cur.live == '0);
      share_b = (BYTES_W+1)'(use_cur.bytes) + (BYTES_W+1)'(nb_ff);
      share_f = (FDS_W+1)'(use_cur.fds) + (FDS_W+1)'(nf_ff);
   end

   usage_entry_type    ev_use_ff;
   logic [BYTES_W-1:0] ev_bl_ff;
   logic [FDS_W-1:0]   ev_fl_ff;
   logic [CW-1:0]      ev_act_ff;
   logic [PBW-1:0]     ev_prod_b_ff;
   logic [PFW-1:0]     ev_prod_f_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         ev_use_ff    <= use_cur;
         ev_bl_ff     <= bl_cur;
         ev_fl_ff     <= fl_cur;
         ev_act_ff    <= act_cur;
         ev_prod_b_ff <= PBW'(share_b) * PBW'(users);
         ev_prod_f_ff <= PFW'(share_f) * PFW'(users);
      end
   end

   // commit stage
   logic               fresh;
   logic [BYTES_W-1:0] diff_b;
   logic [FDS_W-1:0]   diff_f;
   logic               ok_b;
   logic               ok_f;
   logic [BYTES_W:0]   sum_b;
   logic [FDS_W:0]     sum_f;
   logic [LIVE_W-1:0]  live_dec;

   always_comb begin
      fresh    = (ev_use_ff.live == '0);
      diff_b   = ev_bl_ff - nb_ff;
      diff_f   = ev_fl_ff - nf_ff;
      ok_b     = (nb_ff <= ev_bl_ff) && (ev_prod_b_ff <= PBW'(diff_b));
      ok_f     = (nf_ff <= ev_fl_ff) && (ev_prod_f_ff <= PFW'(diff_f));
      sum_b    = (BYTES_W+1)'(ev_bl_ff) + (BYTES_W+1)'(nb_ff);
      sum_f    = (FDS_W+1)'(ev_fl_ff) + (FDS_W+1)'(nf_ff);
      live_dec = ev_use_ff.live - 1'b1;

      status_new = STATUS_OK;
      use_new    = ev_use_ff;
      bl_new     = ev_bl_ff;
      fl_new     = ev_fl_ff;
      act_new    = ev_act_ff;

      if (func_ff == FUNC_CHARGE) begin
         if (ev_use_ff.live == LIVE_MAX) begin
            status_new = STATUS_COUNT_FULL;
         end else if (!ok_b || !ok_f) begin
            status_new = STATUS_QUOTA;
         end else begin
            bl_new        = diff_b;
            fl_new        = diff_f;
            use_new.bytes = ev_use_ff.bytes + nb_ff;
            use_new.fds   = ev_use_ff.fds + nf_ff;
            use_new.live  = ev_use_ff.live + 1'b1;
            act_new       = ev_act_ff + CW'(fresh);
         end
      end else begin
         if (fresh || (nb_ff > ev_use_ff.bytes) || (nf_ff > ev_use_ff.fds)) begin
            status_new = STATUS_NO_CHARGE;
         end else begin
            bl_new        = sum_b[BYTES_W] ? '1 : sum_b[BYTES_W-1:0];
            fl_new        = sum_f[FDS_W] ? '1 : sum_f[FDS_W-1:0];
            use_new.bytes = ev_use_ff.bytes - nb_ff;
            use_new.fds   = ev_use_ff.fds - nf_ff;
            use_new.live  = live_dec;
            if ((live_dec == '0) && (ev_act_ff != '0)) begin
               act_new = ev_act_ff - 1'b1;
            end
         end
      end
   end

   // response register
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BYTES_W-1:0]  rsp_bytes_left_ff;
   logic [FDS_W-1:0]    rsp_fds_left_ff;
   logic [ACTIVE_W-1:0] rsp_actors_active_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff        <= status_new;
         rsp_bytes_left_ff    <= bl_new;
         rsp_fds_left_ff      <= fl_new;
         rsp_actors_active_ff <= ACTIVE_W'(act_new);
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_bytes_left    = rsp_bytes_left_ff;
   assign rsp_fds_left      = rsp_fds_left_ff;
   assign rsp_actors_active = rsp_actors_active_ff;

endmodule

// File: design/fair_share_quota_charger_core.sv
// Top level of the fair share quota charger.
// Instantiates fsqc_ctrl and fsqc_datapath; depends on fsqc_pkg.
//
// Charges and releases byte and descriptor credit of an owner slot on behalf of
// an actor slot, admitting a charge only when it fits the actor's fair share.
// After reset the usage memory is cleared, one entry a cycle, over all
// OWNER_SLOTS * ACTOR_SLOTS entries (256 by default) with req_ready low;
// csr writes are taken meanwhile. For each item the owner and usage memories
// are read at the transfer, the share products are formed in the next cycle
// and compared in the one after, where they are written back once the response
// register is free and the next item can already be accepted. The response sits
// in an output register; a stalled response holds off the following item only
// at its write-back.
module fair_share_quota_charger_core #(
   parameter int OWNER_SLOTS = 16,
   parameter int ACTOR_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [fsqc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fsqc_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [fsqc_pkg::SLOT_IN_W-1:0]     req_owner_slot,
   input  logic [fsqc_pkg::SLOT_IN_W-1:0]     req_actor_slot,
   input  logic [fsqc_pkg::BYTES_W-1:0]       req_amount_bytes,
   input  logic [fsqc_pkg::FDS_W-1:0]         req_amount_fds,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fsqc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fsqc_pkg::BYTES_W-1:0]       rsp_bytes_left,
   output logic [fsqc_pkg::FDS_W-1:0]         rsp_fds_left,
   output logic [fsqc_pkg::ACTIVE_W-1:0]      rsp_actors_active
);
   import fsqc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   fsqc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (dp_status)
   );

   fsqc_datapath #(
      .OWNER_SLOTS (OWNER_SLOTS),
      .ACTOR_SLOTS (ACTOR_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (dp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_func          (req_func),
      .req_owner_slot    (req_owner_slot),
      .req_actor_slot    (req_actor_slot),
      .req_amount_bytes  (req_amount_bytes),
      .req_amount_fds    (req_amount_fds),
      .rsp_status        (rsp_status),
      .rsp_bytes_left    (rsp_bytes_left),
      .rsp_fds_left      (rsp_fds_left),
      .rsp_actors_active (rsp_actors_active)
   );

endmodule

// File: design/fsqc_checker.sv
// Port-level checker for the fair share quota charger, with its bind.
// Depends on fsqc_pkg and fair_share_quota_charger_core.
module fsqc_checker #(
   parameter int ACTOR_SLOTS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fsqc_pkg::ACTIVE_W-1:0] rsp_actors_active
);
   import fsqc_pkg::*;

   // reset starts the clearing sweep: nothing taken, nothing offered
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or response right after reset");

   // a new response is preceded by a request transfer
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("response without matching request transfer");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_actors_active) <= ACTOR_SLOTS))
      else $error("active actor count above actor slots");

endmodule

bind fair_share_quota_charger_core fsqc_checker #(
   .ACTOR_SLOTS (ACTOR_SLOTS)
) u_fsqc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_actors_active (rsp_actors_active)
);

// File: tb/sv/fair_share_quota_charger_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for fair_share_quota_charger_core: directed and random
// charge/release traffic scored against an in-bench credit and usage model.
// Depends on fsqc_pkg and the core RTL.
module fair_share_quota_charger_core_test;
   import fsqc_pkg::*;

   localparam int SLOTS          = SLOT_CODES;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 300;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTES_W-1:0]  bytes_left;
      logic [FDS_W-1:0]    fds_left;
      logic [ACTIVE_W-1:0] actors_active;
   } quota_reply_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_func;
   logic [SLOT_IN_W-1:0]   req_owner_slot;
   logic [SLOT_IN_W-1:0]   req_actor_slot;
   logic [BYTES_W-1:0]     req_amount_bytes;
   logic [FDS_W-1:0]       req_amount_fds;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_W-1:0]    rsp_status;
   logic [BYTES_W-1:0]     rsp_bytes_left;
   logic [FDS_W-1:0]       rsp_fds_left;
   logic [ACTIVE_W-1:0]    rsp_actors_active;

   fair_share_quota_charger_core DUT (.*);

   // credit and usage model
   bit [BYTES_W-1:0] limit_bytes;
   bit [FDS_W-1:0]   limit_fds;
   bit               owner_seen [SLOTS];
   bit [BYTES_W-1:0] credit_bytes [SLOTS];
   bit [FDS_W-1:0]   credit_fds [SLOTS];
   int unsigned      active_count [SLOTS];
   bit [BYTES_W-1:0] held_bytes [SLOTS][SLOTS];
   bit [FDS_W-1:0]   held_fds [SLOTS][SLOTS];
   bit [LIVE_W-1:0]  held_charges [SLOTS][SLOTS];

   quota_reply_type quota_replies_due [$];
   int unsigned  idle_max;
   int unsigned  mismatches;
   int unsigned  requests_sent;
   int unsigned  replies_checked;
   int unsigned  limit_settings;
   int unsigned  status_tally [4];
   int unsigned  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit fits_share(input longint unsigned remaining, users, share, amount);
      if (amount > remaining) return 1'b0;
      return (remaining - amount) >= (share + amount) * users;
   endfunction

   function automatic quota_reply_type settle_quota(input bit func,
                                                    input bit [SLOT_IN_W-1:0] o, a,
                                                    input bit [BYTES_W-1:0] nb,
                                                    input bit [FDS_W-1:0] nf);
      quota_reply_type reply;
      bit              fresh;
      longint unsigned users;
      longint unsigned sum_bytes;
      int unsigned     sum_fds;
      reply.status = STATUS_OK;
      if (!owner_seen[o]) begin
         owner_seen[o]   = 1'b1;
         credit_bytes[o] = limit_bytes;
         credit_fds[o]   = limit_fds;
      end
      if (func == FUNC_CHARGE) begin
         if (held_charges[o][a] == LIVE_MAX) begin
            reply.status = STATUS_COUNT_FULL;
         end else begin
            fresh = (held_charges[o][a] == 0);
            users = active_count[o] + fresh;
            if (!fits_share(credit_bytes[o], users, held_bytes[o][a], nb) ||
                !fits_share(credit_fds[o], users, held_fds[o][a], nf)) begin
               reply.status = STATUS_QUOTA;
            end else begin
               credit_bytes[o]    -= nb;
               credit_fds[o]      -= nf;
               held_bytes[o][a]   += nb;
               held_fds[o][a]     += nf;
               held_charges[o][a] += 1'b1;
               if (fresh) active_count[o]++;
            end
         end
      end else if (held_charges[o][a] == 0 || nb > held_bytes[o][a] ||
                   nf > held_fds[o][a]) begin
         reply.status = STATUS_NO_CHARGE;
      end else begin
         // credit saturates at full width on give-back
         sum_bytes = credit_bytes[o];
         sum_bytes += nb;
         sum_fds = credit_fds[o] + nf;
         credit_bytes[o] = ((sum_bytes >> BYTES_W) != 0) ? '1 : BYTES_W'(sum_bytes);
         credit_fds[o]   = ((sum_fds >> FDS_W) != 0) ? '1 : FDS_W'(sum_fds);
         held_bytes[o][a]   -= nb;
         held_fds[o][a]     -= nf;
         held_charges[o][a] -= 1'b1;
         if (held_charges[o][a] == 0 && active_count[o] > 0) active_count[o]--;
      end
      reply.bytes_left    = credit_bytes[o];
      reply.fds_left      = credit_fds[o];
      reply.actors_active = ACTIVE_W'(active_count[o]);
      status_tally[reply.status]++;
      return reply;
   endfunction

   function automatic int unsigned draw_idle();
      return ($urandom_range(3) == 0) ? 0 : $urandom_range(idle_max);
   endfunction

   // amount around the largest charge the fair share still admits
   function automatic longint unsigned aim_amount(input longint unsigned avail, users, share,
                                                  ceiling);
      longint unsigned cap;
      cap = (share * users > avail) ? 0 : (avail - share * users) / (users + 1);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom_range(32'(cap));
         5, 6: return cap + $urandom_range(1);
         7: return $urandom_range(15);
         default: return $urandom & ceiling;
      endcase
   endfunction

   task automatic issue_request(input bit func, input bit [SLOT_IN_W-1:0] owner, actor,
                                input bit [BYTES_W-1:0] nb, input bit [FDS_W-1:0] nf);
      int unsigned gap;
      gap = draw_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_owner_slot   <= owner;
      req_actor_slot   <= actor;
      req_amount_bytes <= nb;
      req_amount_fds   <= nf;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      quota_replies_due.push_back(settle_quota(func, owner, actor, nb, nf));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (quota_replies_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_limits(input bit [BYTES_W-1:0] new_bytes,
                                 input bit [FDS_W-1:0] new_fds);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_BYTE_LIMIT;
      csr_wr_data <= new_bytes;
      @(negedge clock);
      csr_index   <= CSR_FD_LIMIT;
      csr_wr_data <= CSR_DATA_W'(new_fds);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      limit_bytes = new_bytes;
      limit_fds   = new_fds;
      limit_settings++;
   endtask

   function automatic void check_field(input string field, input logic [BYTES_W-1:0] want, got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   initial begin : reply_checker
      quota_reply_type expected;
      int unsigned     stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = draw_idle();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         replies_checked++;
         if (quota_replies_due.size() == 0) begin
            $error("unexpected response transfer: status %0d bytes_left %0d",
                   rsp_status, rsp_bytes_left);
            mismatches++;
         end else begin
            expected = quota_replies_due.pop_front();
            check_field("status", BYTES_W'(expected.status), BYTES_W'(rsp_status));
            check_field("bytes_left", expected.bytes_left, rsp_bytes_left);
            check_field("fds_left", BYTES_W'(expected.fds_left), BYTES_W'(rsp_fds_left));
            check_field("actors_active", BYTES_W'(expected.actors_active),
                        BYTES_W'(rsp_actors_active));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // owner 0 under the reset-time limits
   task automatic test_reset_limits();
      issue_request(FUNC_RELEASE, 4'd0, 4'd0, 32'd0, 16'd0);
      issue_request(FUNC_CHARGE, 4'd0, 4'd0, 32'h0080_0000, 16'd32);
      issue_request(FUNC_CHARGE, 4'd0, 4'd1, 32'd1, 16'd0);
      issue_request(FUNC_CHARGE, 4'd0, 4'd0, '1, 16'd0);
      issue_request(FUNC_CHARGE, 4'd0, 4'd2, 32'd0, '1);
      issue_request(FUNC_RELEASE, 4'd0, 4'd0, 32'h0080_0000, 16'd32);
      issue_request(FUNC_RELEASE, 4'd0, 4'd1, 32'd2, 16'd0);
   endtask

   task automatic test_limit_extremes();
      program_limits('0, '0);
      issue_request(FUNC_CHARGE, 4'd1, 4'd0, 32'd0, 16'd0);
      issue_request(FUNC_CHARGE, 4'd1, 4'd1, 32'd1, 16'd0);
      issue_request(FUNC_RELEASE, 4'd1, 4'd0, 32'd0, 16'd0);
      program_limits('1, '1);
      issue_request(FUNC_CHARGE, 4'd2, 4'd15, 32'h7FFF_FFFF, 16'h7FFF);
      issue_request(FUNC_CHARGE, 4'd2, 4'd15, '1, '1);
      issue_request(FUNC_RELEASE, 4'd2, 4'd15, '1, '1);
      issue_request(FUNC_RELEASE, 4'd2, 4'd15, 32'h7FFF_FFFF, 16'h7FFF);
   endtask

   // last charge released while usage remains; residue counts as share
   task automatic test_partial_release();
      issue_request(FUNC_CHARGE, 4'd3, 4'd4, 32'd100, 16'd2);
      issue_request(FUNC_CHARGE, 4'd3, 4'd4, 32'd50, 16'd1);
      issue_request(FUNC_RELEASE, 4'd3, 4'd4, 32'd120, 16'd2);
      issue_request(FUNC_RELEASE, 4'd3, 4'd4, 32'd0, 16'd0);
      issue_request(FUNC_CHARGE, 4'd3, 4'd4, 32'd10, 16'd0);
   endtask

   task automatic test_full_actor_set();
      for (int k = 0; k < SLOTS; k++)
         issue_request(FUNC_CHARGE, 4'd15, SLOT_IN_W'(k), 32'd0, 16'd0);
      issue_request(FUNC_RELEASE, 4'd15, 4'd15, 32'd0, 16'd0);
   endtask

   task automatic random_traffic(input int unsigned items, input int unsigned owner_span);
      bit [SLOT_IN_W-1:0] o;
      bit [SLOT_IN_W-1:0] a;
      bit [BYTES_W-1:0]   nb;
      bit [FDS_W-1:0]     nf;
      longint unsigned    users;
      int unsigned        roll;
      repeat (items) begin
         o    = SLOT_IN_W'($urandom_range(owner_span - 1));
         a    = SLOT_IN_W'($urandom_range(SLOTS - 1));
         roll = $urandom_range(99);
         if (roll < 55) begin
            users = active_count[o] + (held_charges[o][a] == 0);
            nb = BYTES_W'(aim_amount(owner_seen[o] ? credit_bytes[o] : limit_bytes, users,
                                     held_bytes[o][a], {BYTES_W{1'b1}}));
            nf = FDS_W'(aim_amount(owner_seen[o] ? credit_fds[o] : limit_fds, users,
                                   held_fds[o][a], {FDS_W{1'b1}}));
            issue_request(FUNC_CHARGE, o, a, nb, nf);
         end else if (roll < 85) begin
            for (int k = 1; k < SLOTS && held_charges[o][a] == 0; k++) a = a + 1'b1;
            case ($urandom_range(3))
               0: begin
                  nb = held_bytes[o][a];
                  nf = held_fds[o][a];
               end
               1: begin
                  nb = '0;
                  nf = '0;
               end
               default: begin
                  nb = $urandom_range(held_bytes[o][a]);
                  nf = FDS_W'($urandom_range(held_fds[o][a]));
               end
            endcase
            issue_request(FUNC_RELEASE, o, a, nb, nf);
         end else if (roll < 95) begin
            if ($urandom_range(1)) begin
               nb = held_bytes[o][a] + 1'b1;
               nf = held_fds[o][a];
            end else begin
               nb = held_bytes[o][a];
               nf = held_fds[o][a] + 1'b1;
            end
            issue_request(FUNC_RELEASE, o, a, nb, nf);
         end else begin
            issue_request(1'($urandom_range(1)), o, a, $urandom, FDS_W'($urandom));
         end
      end
   endtask

   // each phase brings two more owners into use under its own limits
   task automatic test_random_phases();
      bit [BYTES_W-1:0] phase_bytes;
      bit [FDS_W-1:0]   phase_fds;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: begin
               phase_bytes = '0;
               phase_fds   = '0;
            end
            2: begin
               phase_bytes = '1;
               phase_fds   = '1;
            end
            3: begin
               phase_bytes = $urandom_range(4096);
               phase_fds   = FDS_W'($urandom_range(16));
            end
            4: begin
               phase_bytes = BYTE_LIMIT_RESET;
               phase_fds   = FD_LIMIT_RESET;
            end
            default: begin
               phase_bytes = $urandom;
               phase_fds   = FDS_W'($urandom);
            end
         endcase
         program_limits(phase_bytes, phase_fds);
         idle_max = (p == 1) ? 0 : (p == 3) ? 3 : 16;
         random_traffic(PHASE_ITEMS, 6 + 2 * p);
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_func         = FUNC_CHARGE;
      req_owner_slot   = '0;
      req_actor_slot   = '0;
      req_amount_bytes = '0;
      req_amount_fds   = '0;
      limit_bytes      = BYTE_LIMIT_RESET;
      limit_fds        = FD_LIMIT_RESET;
      idle_max         = 16;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_limits();
      test_limit_extremes();
      test_partial_release();
      test_full_actor_set();
      test_random_phases();
      wait_drained();
      repeat (8) @(negedge clock);
      $display("Sent %0d requests under %0d limit settings, checked %0d responses, %0d mismatches",
               requests_sent, limit_settings + 1, replies_checked, mismatches);
      $display("Outcomes: %0d ok, %0d over quota, %0d unmatched release, %0d count full",
               status_tally[STATUS_OK], status_tally[STATUS_QUOTA],
               status_tally[STATUS_NO_CHARGE], status_tally[STATUS_COUNT_FULL]);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
